// File: src/sorted_sequence_number_insert_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted sequence number insert core
// Shared shorthand for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SORTED_SEQUENCE_NUMBER_INSERT_CORE_MACROS_SVH
`define SORTED_SEQUENCE_NUMBER_INSERT_CORE_MACROS_SVH

// Checked only while reset is low.
`define SSNI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSNI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ssni_pkg.sv
// ----------------------------------------------------------------------------
// ssni_pkg
// Types and codes shared by the controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package ssni_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Read address sources of the entry memory.
  typedef enum logic [1:0] {
    RD_LAST  = 2'd0,
    RD_MID   = 2'd1,
    RD_RIDX  = 2'd2,
    RD_SHIFT = 2'd3
  } rd_sel_t;

  // Write sources of the entry memory.
  typedef enum logic {
    WR_SHIFT = 1'b0,
    WR_VAL   = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    slot_cnt;
    logic    slot_low;
    logic    slot_mid;
    logic    srch_init;
    logic    go_high;
    logic    go_low;
    logic    mid_load;
    logic    ptr_init;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    out_load;
    status_t res;
  } ssni_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  read_ok;
    logic  e_equal;
    logic  e_newer;
    logic  v_newer;
    logic  search_on;
    logic  slot_at_cnt;
    logic  shift_last;
  } ssni_stat_t;

  // True when b is strictly newer than a in 16-bit serial order.
  function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] diff;
    diff = b - a;
    return (diff != 16'd0) && !diff[15];
  endfunction

endpackage

// File: src/sorted_sequence_number_insert_core.sv
// Inserts into a non-empty table compare with the last entry and append a newer value; others
// binary-search for their slot with up to log2(DEPTH) probes, rejecting a duplicate found.
// Making room moves one entry per cycle through the memory's one read and one write port.
// One item at a time: the next beat is not accepted until the result beat has registered.
// Reset clears the entry count and handshake state; entry memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_sequence_number_insert_core
// Table of 16-bit sequence numbers kept sorted in wraparound order.
// ----------------------------------------------------------------------------
module sorted_sequence_number_insert_core import ssni_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] seq_value,
  input  logic [5:0]  read_index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [6:0]  position,
  output logic [6:0]  entry_count,
  output logic [15:0] read_value
);

  ssni_cmd_t  cmd;
  ssni_stat_t stat;

  ssni_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssni_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .seq_value   (seq_value),
    .read_index  (read_index),
    .stat        (stat),
    .status      (status),
    .position    (position),
    .entry_count (entry_count),
    .read_value  (read_value)
  );

endmodule

// File: src/ssni_dp.sv
// ----------------------------------------------------------------------------
// ssni_dp
// Entry memory, count, search bounds, shift pointer and result register.
// ----------------------------------------------------------------------------
module ssni_dp import ssni_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  ssni_cmd_t   cmd,
  input  logic [1:0]  mode,
  input  logic [15:0] seq_value,
  input  logic [5:0]  read_index,
  output ssni_stat_t  stat,
  output logic [1:0]  status,
  output logic [6:0]  position,
  output logic [6:0]  entry_count,
  output logic [15:0] read_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0]        mem [DEPTH];
  logic [15:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [15:0]        wr_data;

  mode_t              mode_q;
  logic [15:0]        val_q;
  logic [5:0]         ridx_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      slot;
  logic [CW-1:0]      ptr;
  logic signed [CW:0] low;
  logic signed [CW:0] high;
  logic [AW-1:0]      mid;
  logic signed [CW+1:0] lh_sum;
  logic [AW-1:0]      mid_calc;

  assign lh_sum   = (CW+2)'(low) + (CW+2)'(high);
  assign mid_calc = AW'(lh_sum >>> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:  rd_addr = AW'(count - CW'(1));
      RD_MID:   rd_addr = mid_calc;
      RD_RIDX:  rd_addr = AW'(ridx_q);
      RD_SHIFT: rd_addr = AW'(ptr - CW'(2));
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: begin
        wr_addr = AW'(ptr);
        wr_data = rd_data;
      end
      WR_VAL: begin
        wr_addr = AW'(slot);
        wr_data = val_q;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode_t'(mode);
      val_q  <= seq_value;
      ridx_q <= read_index;
    end
    if (cmd.srch_init) begin
      low  <= '0;
      high <= $signed({1'b0, count}) - $signed((CW+1)'(1));
    end else if (cmd.go_high) begin
      high <= $signed((CW+1)'(mid)) - $signed((CW+1)'(1));
    end else if (cmd.go_low) begin
      low <= $signed((CW+1)'(mid)) + $signed((CW+1)'(1));
    end
    if (cmd.mid_load) begin
      mid <= mid_calc;
    end
    if (cmd.slot_cnt) begin
      slot <= count;
    end else if (cmd.slot_low) begin
      slot <= CW'(low);
    end else if (cmd.slot_mid) begin
      slot <= CW'(mid);
    end
    if (cmd.ptr_init) begin
      ptr <= count;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - CW'(1);
    end
  end

  always_comb begin
    stat.mode        = mode_q;
    stat.full        = (count >= CW'(DEPTH));
    stat.empty       = (count == '0);
    stat.read_ok     = (32'(ridx_q) < 32'(count)) && (32'(ridx_q) < DEPTH);
    stat.e_equal     = (rd_data == val_q);
    stat.e_newer     = seq_newer(val_q, rd_data);
    stat.v_newer     = seq_newer(rd_data, val_q);
    stat.search_on   = (low <= high);
    stat.slot_at_cnt = (slot == count);
    stat.shift_last  = (ptr == slot + CW'(1));
  end

  // The result beat is built from the operation's final state.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.res;
      entry_count <= 7'(count);
      if (mode_q == MODE_INSERT && cmd.res == ST_OK) begin
        position <= 7'(slot);
      end else if (mode_q == MODE_READ) begin
        position <= 7'(ridx_q);
      end else begin
        position <= '0;
      end
      if (mode_q == MODE_READ && cmd.res == ST_OK) begin
        read_value <= rd_data;
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

// File: src/ssni_ctrl.sv
// ----------------------------------------------------------------------------
// ssni_ctrl
// Sequencer for insert, read and clear, with the result beat handshake.
// ----------------------------------------------------------------------------
module ssni_ctrl import ssni_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  ssni_stat_t stat,
  output ssni_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAST_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_START,
    S_SH_RUN,
    S_WR_VAL,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t res;
  status_t res_next;
  logic    rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    res_next       = res;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_next = ST_OK;
        case (stat.mode)
          MODE_INSERT: begin
            if (stat.full) begin
              res_next   = ST_FULL;
              state_next = S_FINISH;
            end else if (stat.empty) begin
              cmd.slot_cnt = 1'b1;
              state_next   = S_WR_VAL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = S_LAST_CMP;
            end
          end
          MODE_READ: begin
            if (stat.read_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_RIDX;
              state_next = S_RD_WAIT;
            end else begin
              res_next   = ST_RANGE;
              state_next = S_FINISH;
            end
          end
          MODE_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_LAST_CMP: begin
        if (stat.v_newer) begin
          cmd.slot_cnt = 1'b1;
          state_next   = S_WR_VAL;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat.search_on) begin
          cmd.mid_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID;
          state_next   = S_SRCH_CMP;
        end else begin
          cmd.slot_low = 1'b1;
          state_next   = S_SH_START;
        end
      end
      S_SRCH_CMP: begin
        if (stat.e_equal) begin
          res_next   = ST_DUP;
          state_next = S_FINISH;
        end else if (stat.e_newer) begin
          cmd.go_high = 1'b1;
          state_next  = S_SRCH_RD;
        end else if (stat.v_newer) begin
          cmd.go_low = 1'b1;
          state_next = S_SRCH_RD;
        end else begin
          // Exactly half the ring apart: the value lands at mid.
          cmd.slot_mid = 1'b1;
          state_next   = S_SH_START;
        end
      end
      S_SH_START: begin
        if (stat.slot_at_cnt) begin
          state_next = S_WR_VAL;
        end else begin
          cmd.ptr_init = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_LAST;
          state_next   = S_SH_RUN;
        end
      end
      S_SH_RUN: begin
        // Write entry ptr from ptr-1 while fetching ptr-2 for the next cycle.
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_SHIFT;
        if (stat.shift_last) begin
          state_next = S_WR_VAL;
        end
      end
      S_WR_VAL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_VAL;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FINISH;
      end
      S_RD_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.res        = res;
    rsp_valid_next = cmd.out_load || (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res       <= ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res       <= res_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: src/ssni_checker.sv
// ----------------------------------------------------------------------------
// ssni_checker
// Port-level checks for the sorted sequence number insert core.
// ----------------------------------------------------------------------------
`include "sorted_sequence_number_insert_core_macros.svh"

module ssni_checker import ssni_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic [6:0]  position,
  input logic [6:0]  entry_count,
  input logic [15:0] read_value
);

  `SSNI_ASSERT_ALWAYS(a_reset_no_beat, rst |=> !rsp_valid, "result beat right after reset")

  `SSNI_ASSERT(a_one_item, (req_valid && !req_stall) |=> req_stall, "second beat taken while busy")

  `SSNI_ASSERT(a_full_count, (rsp_valid && status == ST_FULL) |-> (entry_count == 7'(DEPTH)), "full status without full count")

  `SSNI_ASSERT(a_reject_zero, (rsp_valid && (status == ST_DUP || status == ST_FULL)) |-> (position == 7'd0 && read_value == 16'd0), "rejected insert with nonzero fields")

  `SSNI_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(position) && $stable(entry_count) && $stable(read_value)), "stalled result beat changed")

endmodule

bind sorted_sequence_number_insert_core ssni_checker #(.DEPTH(DEPTH)) u_ssni_checker (.*);
